// ===== design/ucd_pkg.sv =====
`default_nettype none

package ucd_pkg;

    // bytes in a container header and in each file header
    localparam int unsigned HEADER_BYTES = 5;
    // largest file count a container may declare
    localparam int unsigned MAX_FILES    = 2;

    // depth of the command queue between front and back
    localparam int unsigned QUEUE_DEPTH  = 2;
    localparam int unsigned QUEUE_AW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

    // operation codes on the input stream
    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_FINISH  = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // register indexes on the configuration port
    localparam logic [1:0] REG_MAGIC     = 2'd0;
    localparam logic [1:0] REG_APP_CODE  = 2'd1;
    localparam logic [1:0] REG_CORE_CODE = 2'd2;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_FINISH  = 2'd1,
        KIND_RESTART = 2'd2,
        KIND_NOP     = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
    } cmd_t;

    typedef enum logic [2:0] {
        PH_CONTAINER = 3'b001,
        PH_FILEHDR   = 3'b010,
        PH_PAYLOAD   = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        ST_ABSENT   = 2'd0,
        ST_PROGRESS = 2'd1,
        ST_COMPLETE = 2'd2,
        ST_ERROR    = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] container_magic;
        logic [7:0] app_type_code;
        logic [7:0] core_type_code;
    } cfg_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       to_core;
        logic       last_of_file;
        logic       parse_error;
        logic       verify_ok;
        logic       install_app;
        logic       install_core;
    } res_t;

endpackage

`default_nettype wire

// ===== design/ucd_front.sv =====
`default_nettype none

module ucd_front (
    input  wire logic [1:0]    operation,
    input  wire logic [7:0]    data_byte,
    output ucd_pkg::cmd_t      cmd
);

    always_comb
    begin
        cmd.data = data_byte;
        unique case (operation)
            ucd_pkg::OP_BYTE:    cmd.kind = ucd_pkg::KIND_BYTE;
            ucd_pkg::OP_FINISH:  cmd.kind = ucd_pkg::KIND_FINISH;
            ucd_pkg::OP_RESTART: cmd.kind = ucd_pkg::KIND_RESTART;
            default:             cmd.kind = ucd_pkg::KIND_NOP;
        endcase
        // the byte only matters for stream bytes
        if (cmd.kind != ucd_pkg::KIND_BYTE)
        begin
            cmd.data = 8'd0;
        end
    end

endmodule

`default_nettype wire

// ===== design/ucd_queue.sv =====
`default_nettype none

module ucd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire ucd_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output ucd_pkg::cmd_t      head_cmd
);

    localparam int unsigned AW = ucd_pkg::QUEUE_AW;
    localparam int unsigned CW = ucd_pkg::QUEUE_CW;

    ucd_pkg::cmd_t entry_reg [ucd_pkg::QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full       = (count_reg == CW'(ucd_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(ucd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(ucd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("queue written while full");
    assert property (@(posedge clk) disable iff (!rst_n) !head_valid |-> !pop)
        else $error("queue read while empty");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on write");

endmodule

`default_nettype wire

// ===== design/ucd_back.sv =====
`default_nettype none

module ucd_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ucd_pkg::cfg_t cfg,
    input  wire logic          cmd_valid,
    input  wire ucd_pkg::cmd_t cmd,
    output logic               cmd_pop,
    output logic               res_valid,
    output ucd_pkg::res_t      res,
    input  wire logic          res_ready
);

    localparam logic [2:0] HDR_LAST = 3'(ucd_pkg::HEADER_BYTES - 1);

    ucd_pkg::phase_t  phase_reg, phase_next;
    logic [2:0]       hcount_reg, hcount_next;
    logic [31:0]      hword_reg, hword_next;
    logic [7:0]       htype_reg, htype_next;
    logic [4:0]       files_reg, files_next;
    logic [4:0]       findex_reg, findex_next;
    logic             is_core_reg, is_core_next;
    logic [31:0]      left_reg, left_next;
    ucd_pkg::status_t status_reg [2];
    ucd_pkg::status_t status_next [2];
    logic             error_reg, error_next;
    logic             res_valid_reg;
    ucd_pkg::res_t    res_reg, res_next;

    logic             hdr_done;
    logic             cur_t;
    logic             routed;
    logic             fin_ok;

    assign cmd_pop   = cmd_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        hcount_next    = hcount_reg;
        hword_next     = hword_reg;
        htype_next     = htype_reg;
        files_next     = files_reg;
        findex_next    = findex_reg;
        is_core_next   = is_core_reg;
        left_next      = left_reg;
        status_next[0] = status_reg[0];
        status_next[1] = status_reg[1];
        error_next     = error_reg;
        res_next       = '0;
        hdr_done       = (hcount_reg == HDR_LAST);
        cur_t          = is_core_reg;
        routed         = (status_reg[is_core_reg] != ucd_pkg::ST_ERROR);
        fin_ok         = (status_reg[0] == ucd_pkg::ST_ABSENT
                          || status_reg[0] == ucd_pkg::ST_COMPLETE)
                         && (status_reg[1] == ucd_pkg::ST_ABSENT
                          || status_reg[1] == ucd_pkg::ST_COMPLETE);

        case (cmd.kind)
            ucd_pkg::KIND_BYTE:
            begin
                if (!error_reg)
                begin
                    unique case (phase_reg) inside
                        ucd_pkg::PH_CONTAINER, ucd_pkg::PH_FILEHDR:
                        begin
                            if (phase_reg == ucd_pkg::PH_FILEHDR && hcount_reg == 3'd0
                                && findex_reg >= files_reg)
                            begin
                                // byte after all declared files
                                error_next = 1'b1;
                            end
                            else
                            begin
                                if (hcount_reg == 3'd0)
                                begin
                                    htype_next = cmd.data;
                                    hword_next = 32'd0;
                                end
                                else
                                begin
                                    hword_next = {hword_reg[23:0], cmd.data};
                                end
                                hcount_next = hdr_done ? 3'd0 : hcount_reg + 3'd1;
                                if (hdr_done && phase_reg == ucd_pkg::PH_CONTAINER)
                                begin
                                    if (htype_reg != cfg.container_magic
                                        || hword_next > 32'(ucd_pkg::MAX_FILES))
                                    begin
                                        error_next = 1'b1;
                                    end
                                    else
                                    begin
                                        files_next  = hword_next[4:0];
                                        findex_next = 5'd0;
                                        phase_next  = ucd_pkg::PH_FILEHDR;
                                    end
                                end
                                else if (hdr_done)
                                begin
                                    if (htype_reg == cfg.app_type_code)
                                    begin
                                        cur_t = 1'b0;
                                    end
                                    else
                                    begin
                                        cur_t = 1'b1;
                                    end
                                    if (htype_reg != cfg.app_type_code
                                        && htype_reg != cfg.core_type_code)
                                    begin
                                        error_next = 1'b1;
                                    end
                                    else
                                    begin
                                        is_core_next = cur_t;
                                        left_next    = hword_next;
                                        if (status_reg[cur_t] != ucd_pkg::ST_ABSENT)
                                        begin
                                            status_next[cur_t] = ucd_pkg::ST_ERROR;
                                        end
                                        else if (hword_next == 32'd0)
                                        begin
                                            status_next[cur_t] = ucd_pkg::ST_COMPLETE;
                                        end
                                        else
                                        begin
                                            status_next[cur_t] = ucd_pkg::ST_PROGRESS;
                                        end
                                        if (hword_next == 32'd0)
                                        begin
                                            findex_next = findex_reg + 5'd1;
                                        end
                                        else
                                        begin
                                            phase_next = ucd_pkg::PH_PAYLOAD;
                                        end
                                    end
                                end
                            end
                        end
                        ucd_pkg::PH_PAYLOAD:
                        begin
                            left_next = left_reg - 32'd1;
                            if (routed)
                            begin
                                res_next.payload_valid = 1'b1;
                                res_next.payload_byte  = cmd.data;
                                res_next.to_core       = is_core_reg;
                            end
                            if (left_reg == 32'd1)
                            begin
                                res_next.last_of_file = routed;
                                if (status_reg[is_core_reg] == ucd_pkg::ST_PROGRESS)
                                begin
                                    status_next[is_core_reg] = ucd_pkg::ST_COMPLETE;
                                end
                                findex_next = findex_reg + 5'd1;
                                phase_next  = ucd_pkg::PH_FILEHDR;
                            end
                        end
                        default:
                        begin
                            phase_next = ucd_pkg::PH_CONTAINER;
                        end
                    endcase
                end
            end
            ucd_pkg::KIND_FINISH:
            begin
                if (fin_ok)
                begin
                    res_next.verify_ok    = 1'b1;
                    res_next.install_app  = (status_reg[0] == ucd_pkg::ST_COMPLETE);
                    res_next.install_core = (status_reg[1] == ucd_pkg::ST_COMPLETE);
                    status_next[0]        = ucd_pkg::ST_ABSENT;
                    status_next[1]        = ucd_pkg::ST_ABSENT;
                end
            end
            ucd_pkg::KIND_RESTART:
            begin
                phase_next     = ucd_pkg::PH_CONTAINER;
                hcount_next    = 3'd0;
                hword_next     = 32'd0;
                htype_next     = 8'd0;
                files_next     = 5'd0;
                findex_next    = 5'd0;
                is_core_next   = 1'b0;
                left_next      = 32'd0;
                status_next[0] = ucd_pkg::ST_ABSENT;
                status_next[1] = ucd_pkg::ST_ABSENT;
                error_next     = 1'b0;
            end
            default:
            begin
                error_next = error_reg;
            end
        endcase
        res_next.parse_error = error_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ucd_pkg::PH_CONTAINER;
            hcount_reg    <= 3'd0;
            hword_reg     <= 32'd0;
            htype_reg     <= 8'd0;
            files_reg     <= 5'd0;
            findex_reg    <= 5'd0;
            is_core_reg   <= 1'b0;
            left_reg      <= 32'd0;
            status_reg[0] <= ucd_pkg::ST_ABSENT;
            status_reg[1] <= ucd_pkg::ST_ABSENT;
            error_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_pop)
            begin
                phase_reg     <= phase_next;
                hcount_reg    <= hcount_next;
                hword_reg     <= hword_next;
                htype_reg     <= htype_next;
                files_reg     <= files_next;
                findex_reg    <= findex_next;
                is_core_reg   <= is_core_next;
                left_reg      <= left_next;
                status_reg[0] <= status_next[0];
                status_reg[1] <= status_next[1];
                error_reg     <= error_next;
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            res_reg <= res_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(res_reg.payload_valid && res_reg.verify_ok))
        else $error("payload and finish result in one transaction");
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.last_of_file) |-> res_reg.payload_valid)
        else $error("last marker on a byte that is not payload");
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_reg.install_app || res_reg.install_core))
        |-> res_reg.verify_ok)
        else $error("install without a passed check");
    assert property (@(posedge clk) disable iff (!rst_n)
        (error_reg && cmd_pop && cmd.kind != ucd_pkg::KIND_RESTART) |=> error_reg)
        else $error("error flag dropped without restart");
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == ucd_pkg::PH_PAYLOAD) |-> (left_reg != 32'd0))
        else $error("payload phase with nothing left");

endmodule

`default_nettype wire

// ===== design/update_container_deframer.sv =====
`default_nettype none

// Update container deframer. Takes a firmware-update stream one transaction
// per byte on the s_ side: tdata[1:0] is the operation (stream byte, finish,
// restart) and tdata[9:2] the byte. Every input transaction yields exactly
// one output transaction on the m_ side carrying routed payload (with its
// destination and a tlast on each file's final byte), the sticky parse
// error flag and, for a finish, the verify and install decisions. The magic
// byte and the two file type codes are set over the APB-style port at byte
// addresses 0, 4 and 8; the user must write them only while the block is
// idle; the block does not enforce this. Throughput is one transaction
// per clock while m_tready keeps up: the parser keeps all its state in
// registers and updates header shift, file counters and the 32-bit
// payload down-counter together. Inputs pass the two-entry command
// queue, then the output register; the queue fills while m_tready is low.

module update_container_deframer (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // apb-style configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // operation[1:0], data_byte[9:2], zero[15:10]

    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // payload_valid[0], payload_byte[8:1], to_core[9],
                                        // parse_error[10], verify_ok[11], install_app[12],
                                        // install_core[13], zero[15:14]
    output logic             m_tlast    // last_of_file
);

    ucd_pkg::cfg_t cfg_reg;
    logic          cfg_write;

    ucd_pkg::cmd_t front_cmd;
    logic          q_full;
    logic          q_push;
    logic          q_valid;
    ucd_pkg::cmd_t q_cmd;
    logic          q_pop;
    ucd_pkg::res_t res;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                ucd_pkg::REG_MAGIC:     cfg_reg.container_magic <= pwdata[7:0];
                ucd_pkg::REG_APP_CODE:  cfg_reg.app_type_code   <= pwdata[7:0];
                ucd_pkg::REG_CORE_CODE: cfg_reg.core_type_code  <= pwdata[7:0];
                default:                cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            ucd_pkg::REG_MAGIC:     prdata = {24'd0, cfg_reg.container_magic};
            ucd_pkg::REG_APP_CODE:  prdata = {24'd0, cfg_reg.app_type_code};
            ucd_pkg::REG_CORE_CODE: prdata = {24'd0, cfg_reg.core_type_code};
            default:                prdata = 32'd0;
        endcase
    end

    // front: decode the operation into a command
    ucd_front u_front (
        .operation (s_tdata[1:0]),
        .data_byte (s_tdata[9:2]),
        .cmd       (front_cmd)
    );

    // short queue decouples acceptance from the parser
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    ucd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (front_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_cmd)
    );

    // back: parser state and output register
    ucd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .cmd_pop   (q_pop),
        .res_valid (m_tvalid),
        .res       (res),
        .res_ready (m_tready)
    );

    assign m_tdata = {2'b00, res.install_core, res.install_app, res.verify_ok,
                      res.parse_error, res.to_core, res.payload_byte, res.payload_valid};
    assign m_tlast = res.last_of_file;

endmodule

`default_nettype wire

// ===== tb/update_container_deframer_tb.sv =====
`default_nettype none

// testbench for the update container deframer
// - a small class mirrors the parser: every accepted input transaction yields one
//   predicted result, which is queued and compared field by field against the
//   next accepted output transaction
// - a short directed run opens, then random sessions follow: mostly well-formed
//   containers with random content, mixed with corrupted headers, truncated
//   files, excess bytes and noise
// - sender and receiver idle at random; the receiver holds off once for a long
//   stretch so that the block backs up and stalls its input

module update_container_deframer_tb;

    import ucd_pkg::*;

    // watchdog limit, in cycles with no accepted transaction on either side
    localparam int unsigned IDLE_LIMIT  = 2000;
    // results taken before the long receiver hold-off starts
    localparam int unsigned HOLD_AT     = 150;
    localparam int unsigned HOLD_CYCLES = 120;
    // random input transactions per configuration phase
    localparam int unsigned PHASE_ITEMS = 170;

    // mirror of the deframer: state, registers and queued predictions
    class deframe_checker;
        logic [7:0]  magic;
        logic [7:0]  app_code;
        logic [7:0]  core_code;
        phase_t      phase;
        logic [2:0]  hdr_count;
        logic [31:0] hdr_word;
        logic [7:0]  hdr_type;
        logic [4:0]  files_declared;
        logic [4:0]  file_index;
        logic        cur_core;
        logic [31:0] payload_left;
        status_t     type_state [2];
        logic        err;
        res_t        outcome;
        res_t        expected_results [$];
        int unsigned errors;

        function new();
            magic     = '0;
            app_code  = '0;
            core_code = '0;
            errors    = 0;
            clear_parser();
        endfunction

        function void clear_parser();
            phase          = PH_CONTAINER;
            hdr_count      = '0;
            hdr_word       = '0;
            hdr_type       = '0;
            files_declared = '0;
            file_index     = '0;
            cur_core       = 1'b0;
            payload_left   = '0;
            type_state[0]  = ST_ABSENT;
            type_state[1]  = ST_ABSENT;
            err            = 1'b0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] value);
            case (idx)
                REG_MAGIC:     magic = value;
                REG_APP_CODE:  app_code = value;
                REG_CORE_CODE: core_code = value;
                default: ;
            endcase
        endfunction

        // first header byte is the magic or type, the rest a big-endian word
        function bit shift_header(logic [7:0] b);
            if (hdr_count == 3'd0)
            begin
                hdr_type = b;
                hdr_word = '0;
            end
            else
                hdr_word = {hdr_word[23:0], b};
            hdr_count = hdr_count + 3'd1;
            if (32'(hdr_count) >= HEADER_BYTES)
            begin
                hdr_count = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void take_stream_byte(logic [7:0] b);
            logic t;
            bit   routed;
            // sticky error: bytes are dropped until restart
            if (err)
                return;
            if (phase == PH_CONTAINER)
            begin
                if (shift_header(b))
                begin
                    if (hdr_type != magic || hdr_word > MAX_FILES)
                        err = 1'b1;
                    else
                    begin
                        files_declared = hdr_word[4:0];
                        file_index     = '0;
                        phase          = PH_FILEHDR;
                    end
                end
                return;
            end
            if (phase == PH_FILEHDR)
            begin
                // a header starting after the last declared file is excess data
                if (hdr_count == 3'd0 && file_index >= files_declared)
                begin
                    err = 1'b1;
                    return;
                end
                if (shift_header(b))
                begin
                    // app code wins when both codes match
                    if (hdr_type == app_code)
                        cur_core = 1'b0;
                    else if (hdr_type == core_code)
                        cur_core = 1'b1;
                    else
                    begin
                        err = 1'b1;
                        return;
                    end
                    t = cur_core;
                    type_state[t] = (type_state[t] != ST_ABSENT) ? ST_ERROR : ST_PROGRESS;
                    payload_left  = hdr_word;
                    if (payload_left == '0)
                    begin
                        // zero-size file closes with its header
                        if (type_state[t] == ST_PROGRESS)
                            type_state[t] = ST_COMPLETE;
                        file_index = file_index + 5'd1;
                    end
                    else
                        phase = PH_PAYLOAD;
                end
                return;
            end
            // payload: a repeated type is consumed but not routed
            t      = cur_core;
            routed = (type_state[t] != ST_ERROR);
            payload_left = payload_left - 32'd1;
            if (routed)
            begin
                outcome.payload_valid = 1'b1;
                outcome.payload_byte  = b;
                outcome.to_core       = t;
            end
            if (payload_left == '0)
            begin
                if (routed)
                    outcome.last_of_file = 1'b1;
                if (type_state[t] == ST_PROGRESS)
                    type_state[t] = ST_COMPLETE;
                file_index = file_index + 5'd1;
                phase      = PH_FILEHDR;
            end
        endfunction

        function void decide_finish();
            bit app_ok;
            bit core_ok;
            app_ok  = (type_state[0] == ST_ABSENT || type_state[0] == ST_COMPLETE);
            core_ok = (type_state[1] == ST_ABSENT || type_state[1] == ST_COMPLETE);
            // a failed finish leaves everything as it was
            if (!(app_ok && core_ok))
                return;
            outcome.verify_ok    = 1'b1;
            outcome.install_app  = (type_state[0] == ST_COMPLETE);
            outcome.install_core = (type_state[1] == ST_COMPLETE);
            type_state[0] = ST_ABSENT;
            type_state[1] = ST_ABSENT;
        endfunction

        // note an accepted input transaction and queue its result
        function void accept_command(logic [1:0] op, logic [7:0] b);
            outcome = '0;
            case (op)
                OP_BYTE:    take_stream_byte(b);
                OP_FINISH:  decide_finish();
                OP_RESTART: clear_parser();
                default: ;
            endcase
            outcome.parse_error = err;
            expected_results.push_back(outcome);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (expected_results.size() == 0)
            begin
                $error("result transaction with no expectation waiting");
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("payload_valid", want.payload_valid, got.payload_valid);
            compare_field("payload_byte", want.payload_byte, got.payload_byte);
            compare_field("to_core", want.to_core, got.to_core);
            compare_field("last_of_file", want.last_of_file, got.last_of_file);
            compare_field("parse_error", want.parse_error, got.parse_error);
            compare_field("verify_ok", want.verify_ok, got.verify_ok);
            compare_field("install_app", want.install_app, got.install_app);
            compare_field("install_core", want.install_core, got.install_core);
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // operation[1:0], data_byte[9:2], zero[15:10]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // payload_valid[0], payload_byte[8:1], to_core[9],
                            // parse_error[10], verify_ok[11], install_app[12],
                            // install_core[13], zero[15:14]
    logic        m_tlast;   // last_of_file

    // handshake state captured mid-cycle, acted on at the next rising edge
    bit          s_fire;
    bit          m_fire;
    bit          pready_seen;
    logic [15:0] m_word;
    logic        m_last_seen;

    // no random gaps on either side while set; the long hold-off still applies
    bit          burst;
    int unsigned items_sent;
    int unsigned idle_cycles;

    deframe_checker board = new();

    update_container_deframer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #6 clk = ~clk;

    // inputs only move at rising edges, so the falling edge sees settled values
    always @(negedge clk)
    begin
        s_fire      = s_tvalid && s_tready;
        m_fire      = m_tvalid && m_tready;
        pready_seen = pready;
        m_word      = m_tdata;
        m_last_seen = m_tlast;
    end

    // watchdog: too long without any accepted transaction ends the run
    always @(posedge clk)
    begin
        if (!rst_n || s_fire || m_fire)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("update_container_deframer_tb: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function logic [7:0] rand_byte();
        logic [31:0] w;
        w = $urandom();
        return w[7:0];
    endfunction

    // noise leans on stream bytes, with some finish and restart mixed in
    function logic [1:0] noise_op();
        case ($urandom_range(0, 5))
            0:       return OP_FINISH;
            1:       return OP_RESTART;
            default: return OP_BYTE;
        endcase
    endfunction

    // register write: setup cycle, then access cycle until pready
    task write_reg(input logic [1:0] idx, input logic [7:0] value);
        logic [31:0] w;
        w      = $urandom();
        w[7:0] = value;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= w;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready_seen)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_reg(idx, value);
    endtask

    // one input transaction after a random gap; valid stays high afterwards
    task send_item(input logic [1:0] op, input logic [7:0] b);
        int unsigned gap;
        gap = burst ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, b, op};
        @(posedge clk);
        while (!s_fire)
            @(posedge clk);
        board.accept_command(op, b);
        items_sent++;
    endtask

    // big-endian count or size
    task send_word32(input logic [31:0] w);
        send_item(OP_BYTE, w[31:24]);
        send_item(OP_BYTE, w[23:16]);
        send_item(OP_BYTE, w[15:8]);
        send_item(OP_BYTE, w[7:0]);
    endtask

    // file header and payload; huge sizes and some small ones are cut short
    task send_file(input logic [7:0] ftype, input logic [31:0] fsize, output bit whole);
        int unsigned n;
        whole = 1'b1;
        send_item(OP_BYTE, ftype);
        send_word32(fsize);
        if (fsize > 32'd6)
        begin
            n     = $urandom_range(1, 4);
            whole = 1'b0;
        end
        else
            n = fsize;
        if (n > 0 && $urandom_range(0, 9) == 0)
        begin
            n     = $urandom_range(0, n - 1);
            whole = 1'b0;
        end
        repeat (n) send_item(OP_BYTE, rand_byte());
    endtask

    // one random session: mostly a container with random files, sometimes noise
    task run_session();
        int unsigned sel;
        int unsigned nfiles;
        logic [31:0] count;
        logic [31:0] fsize;
        logic [7:0]  ftype;
        bit          whole;
        burst = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 8)) send_item(noise_op(), rand_byte());
            return;
        end
        if ($urandom_range(0, 3) != 0)
            send_item(OP_RESTART, rand_byte());
        // container header, now and then with a wrong magic or a huge count
        send_item(OP_BYTE, ($urandom_range(0, 9) == 0) ? rand_byte() : board.magic);
        if ($urandom_range(0, 9) == 0)
            count = $urandom();
        else
            count = $urandom_range(0, MAX_FILES);
        send_word32(count);
        nfiles = (count <= MAX_FILES) ? count : $urandom_range(0, MAX_FILES);
        // an extra file header beyond the declared count
        if ($urandom_range(0, 4) == 0)
            nfiles++;
        whole = 1'b1;
        for (int i = 0; i < nfiles && whole; i++)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 4)
                ftype = board.app_code;
            else if (sel < 8)
                ftype = board.core_code;
            else
                ftype = rand_byte();
            sel = $urandom_range(0, 9);
            if (sel == 0)
                fsize = '0;
            else if (sel == 1)
                fsize = $urandom();
            else
                fsize = $urandom_range(1, 6);
            send_file(ftype, fsize, whole);
        end
        // trailing excess byte
        if (whole && $urandom_range(0, 4) == 0)
            send_item(OP_BYTE, rand_byte());
        if ($urandom_range(0, 4) != 0)
            send_item(OP_FINISH, rand_byte());
    endtask

    // registers change only with nothing in flight
    task quiesce();
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task configure(input logic [7:0] magic, input logic [7:0] app, input logic [7:0] core);
        write_reg(REG_MAGIC, magic);
        write_reg(REG_APP_CODE, app);
        write_reg(REG_CORE_CODE, core);
    endtask

    // receiver: random ready gaps, one long hold-off to back the block up
    initial
    begin
        int unsigned stall;
        int unsigned taken;
        res_t        got;
        m_tready <= 1'b0;
        taken = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (taken == HOLD_AT)
                stall = HOLD_CYCLES;
            else
                stall = burst ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_fire)
                @(posedge clk);
            got.payload_valid = m_word[0];
            got.payload_byte  = m_word[8:1];
            got.to_core       = m_word[9];
            got.last_of_file  = m_last_seen;
            got.parse_error   = m_word[10];
            got.verify_ok     = m_word[11];
            got.install_app   = m_word[12];
            got.install_core  = m_word[13];
            board.check_result(got);
            taken++;
        end
    end

    // sender and sequencing of phases
    initial
    begin
        logic [7:0]  shared_code;
        int unsigned target;
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        burst      = 1'b0;
        items_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extreme codes, app 0x00 and core 0xff, the core code sharing the magic value
        configure(8'hFF, 8'h00, 8'hFF);
        send_item(OP_RESTART, rand_byte());
        // good container, two files declared
        send_item(OP_BYTE, 8'hFF);
        send_word32(32'd2);
        // app file of one byte, tlast on it
        send_item(OP_BYTE, 8'h00);
        send_word32(32'd1);
        send_item(OP_BYTE, 8'h80);
        // repeated app type: payload consumed but not routed
        send_item(OP_BYTE, 8'h00);
        send_word32(32'd1);
        send_item(OP_BYTE, 8'h7F);
        // finish fails on the errored app status
        send_item(OP_FINISH, rand_byte());
        // byte past the declared files, then one dropped under the sticky error
        send_item(OP_BYTE, 8'h5A);
        send_item(OP_BYTE, 8'hA5);
        send_item(OP_RESTART, rand_byte());
        // bad magic
        send_item(OP_BYTE, 8'h00);
        send_word32(32'd1);

        // random phases over several register settings
        for (int p = 0; p < 4; p++)
        begin
            quiesce();
            case (p)
                0: configure(8'h00, 8'hFF, 8'h00);
                1:
                begin
                    // equal codes: app takes precedence
                    shared_code = rand_byte();
                    configure(rand_byte(), shared_code, shared_code);
                end
                default: configure(rand_byte(), rand_byte(), rand_byte());
            endcase
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
                run_session();
        end

        // drain, then give the block time to show any stray result
        quiesce();
        repeat (8) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("update_container_deframer_tb: done, clean");
        else
            $display("update_container_deframer_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

// ===== update_container_deframer.f =====
design/ucd_pkg.sv
design/ucd_front.sv
design/ucd_queue.sv
design/ucd_back.sv
design/update_container_deframer.sv
tb/update_container_deframer_tb.sv
